>>> rtl/tbr_pkg.sv
// ----------------------------------------------------------------------------
// Timed Bezier ramp package
// Shared widths, codes and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package tbr_pkg;

    localparam int TIME_W     = 32;
    localparam int ELAPSED_W  = 20;
    localparam int VALUE_W    = 32;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int FRAC_W     = 16;
    localparam int WEIGHT_W   = FRAC_W + 1;
    localparam int PROD_W     = 50;
    localparam int SUM_W      = 50;
    localparam int DIV_CNT_W  = 4;
    localparam int STEP_W     = 4;

    localparam logic [WEIGHT_W-1:0]  ONE_Q16  = WEIGHT_W'(1) << FRAC_W;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(FRAC_W - 1);

    // input item kinds
    localparam logic OP_ADVANCE = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    // curve modes; any mode with the high bit set is cubic
    localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUAD   = 2'd1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_TIME  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURVE_MODE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_VALUE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MID_VALUE_A = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MID_VALUE_B = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_VALUE   = 3'd5;

    // multiply steps, in issue order
    typedef enum logic [STEP_W-1:0] {
        STEP_AA  = 4'd0,
        STEP_BB  = 4'd1,
        STEP_AB  = 4'd2,
        STEP_AAA = 4'd3,
        STEP_AAB = 4'd4,
        STEP_ABB = 4'd5,
        STEP_BBB = 4'd6,
        STEP_C0  = 4'd7,
        STEP_C1  = 4'd8,
        STEP_C2  = 4'd9,
        STEP_C3  = 4'd10
    } step_t;

    typedef struct packed {
        logic  load;
        logic  div_init;
        logic  div_step;
        logic  setup;
        logic  mul_issue;
        logic  mul_retire;
        step_t step;
        logic  finish;
        logic  emit;
    } cmd_t;

    typedef struct packed {
        logic compute;
        logic out_free;
    } status_t;

endpackage

>>> rtl/tbr_datapath.sv
// ----------------------------------------------------------------------------
// Timed Bezier ramp datapath
// Config registers, time accumulator, serial divider, shared multiplier,
// Bernstein weights, blend accumulator and the output register.
// ----------------------------------------------------------------------------
module tbr_datapath
    import tbr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  cmd_t                  cmd,
    output status_t               status,
    input  logic                  in_op,
    input  logic [ELAPSED_W-1:0]  in_elapsed,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [VALUE_W-1:0]    cfg_data,
    input  logic                  out_ready,
    output logic                  out_valid,
    output logic [VALUE_W-1:0]    out_value,
    output logic                  out_finished
);

    logic [TIME_W-1:0]         total_time_reg;
    logic [MODE_W-1:0]         curve_mode_reg;
    logic signed [VALUE_W-1:0] start_value_reg;
    logic signed [VALUE_W-1:0] mid_value_a_reg;
    logic signed [VALUE_W-1:0] mid_value_b_reg;
    logic signed [VALUE_W-1:0] end_value_reg;

    logic [TIME_W-1:0]   acc_reg;
    logic [TIME_W-1:0]   acc_next;
    logic [TIME_W:0]     acc_sum;
    logic                done_reg;
    logic [VALUE_W-1:0]  held_reg;

    logic [TIME_W-1:0]   rem_reg;
    logic [FRAC_W-1:0]   q_reg;
    logic                sat_reg;
    logic [TIME_W:0]     rem_shift;

    logic [WEIGHT_W-1:0] pos_b;
    logic [WEIGHT_W-1:0] pos_a;
    logic [WEIGHT_W-1:0] aa_reg;
    logic [WEIGHT_W-1:0] bb_reg;
    logic [WEIGHT_W-1:0] w_reg [4];

    logic signed [TIME_W:0]       mul_x;
    logic signed [WEIGHT_W:0]     mul_y;
    logic signed [TIME_W+WEIGHT_W+1:0] mul_full;
    logic signed [PROD_W-1:0]     p_reg;
    logic signed [SUM_W-1:0]      sum_reg;
    logic [35:0]                  p_triple;
    logic [WEIGHT_W-1:0]          w_shr16;
    logic [WEIGHT_W-1:0]          w_shr15;
    logic [WEIGHT_W-1:0]          w_tri16;

    logic is_quad;
    logic is_cubic;

    logic                 out_valid_reg;
    logic [VALUE_W-1:0]   out_value_reg;
    logic                 out_finished_reg;

    assign is_quad  = (curve_mode_reg == MODE_QUAD);
    assign is_cubic = curve_mode_reg[MODE_W-1];

    // ---------------- configuration ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_time_reg  <= TIME_W'(1000000);
            curve_mode_reg  <= MODE_LINEAR;
            start_value_reg <= '0;
            mid_value_a_reg <= '0;
            mid_value_b_reg <= '0;
            end_value_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TOTAL_TIME:  total_time_reg  <= cfg_data;
                REG_CURVE_MODE:  curve_mode_reg  <= cfg_data[MODE_W-1:0];
                REG_START_VALUE: start_value_reg <= cfg_data;
                REG_MID_VALUE_A: mid_value_a_reg <= cfg_data;
                REG_MID_VALUE_B: mid_value_b_reg <= cfg_data;
                REG_END_VALUE:   end_value_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- ramp state ----------------
    assign acc_sum  = {1'b0, acc_reg} + {{(TIME_W + 1 - ELAPSED_W){1'b0}}, in_elapsed};
    assign acc_next = acc_sum[TIME_W] ? '1 : acc_sum[TIME_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            done_reg <= 1'b0;
            held_reg <= '0;
        end
        else
        begin
            if (cmd.load)
            begin
                if (in_op == OP_RESTART)
                begin
                    acc_reg  <= '0;
                    done_reg <= 1'b0;
                end
                else if (!done_reg)
                begin
                    acc_reg <= acc_next;
                end
            end
            if (cmd.finish)
            begin
                held_reg <= sum_reg[FRAC_W+VALUE_W-1:FRAC_W];
                done_reg <= sat_reg;
            end
        end
    end

    assign status.compute  = (in_op == OP_ADVANCE) && !done_reg;
    assign status.out_free = !out_valid_reg || out_ready;

    // ---------------- restoring divider: acc * 2^16 / total ----------------
    // Remainder stays below total only if acc < total; else sat_reg sets 1.0.
    assign rem_shift = {rem_reg, 1'b0};

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg <= acc_reg;
            q_reg   <= '0;
            sat_reg <= (acc_reg >= total_time_reg);
        end
        else if (cmd.div_step)
        begin
            if (rem_shift >= {1'b0, total_time_reg})
            begin
                rem_reg <= TIME_W'(rem_shift - {1'b0, total_time_reg});
                q_reg   <= {q_reg[FRAC_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift[TIME_W-1:0];
                q_reg   <= {q_reg[FRAC_W-2:0], 1'b0};
            end
        end
    end

    assign pos_b = sat_reg ? ONE_Q16 : {1'b0, q_reg};
    assign pos_a = ONE_Q16 - pos_b;

    // ---------------- shared multiplier ----------------
    always_comb
    begin
        mul_x = '0;
        mul_y = '0;
        unique case (cmd.step)
            STEP_AA:
            begin
                mul_x = $signed({16'd0, pos_a});
                mul_y = $signed({1'b0, pos_a});
            end
            STEP_BB:
            begin
                mul_x = $signed({16'd0, pos_b});
                mul_y = $signed({1'b0, pos_b});
            end
            STEP_AB:
            begin
                mul_x = $signed({16'd0, pos_a});
                mul_y = $signed({1'b0, pos_b});
            end
            STEP_AAA:
            begin
                mul_x = $signed({16'd0, aa_reg});
                mul_y = $signed({1'b0, pos_a});
            end
            STEP_AAB:
            begin
                mul_x = $signed({16'd0, aa_reg});
                mul_y = $signed({1'b0, pos_b});
            end
            STEP_ABB:
            begin
                mul_x = $signed({16'd0, bb_reg});
                mul_y = $signed({1'b0, pos_a});
            end
            STEP_BBB:
            begin
                mul_x = $signed({16'd0, bb_reg});
                mul_y = $signed({1'b0, pos_b});
            end
            STEP_C0:
            begin
                mul_x = {start_value_reg[VALUE_W-1], start_value_reg};
                mul_y = $signed({1'b0, w_reg[0]});
            end
            STEP_C1:
            begin
                mul_x = {mid_value_a_reg[VALUE_W-1], mid_value_a_reg};
                mul_y = $signed({1'b0, w_reg[1]});
            end
            STEP_C2:
            begin
                mul_x = {mid_value_b_reg[VALUE_W-1], mid_value_b_reg};
                mul_y = $signed({1'b0, w_reg[2]});
            end
            STEP_C3:
            begin
                mul_x = {end_value_reg[VALUE_W-1], end_value_reg};
                mul_y = $signed({1'b0, w_reg[3]});
            end
            default: ;
        endcase
    end

    assign mul_full = mul_x * mul_y;

    // weight candidates from the registered product
    assign w_shr16  = p_reg[FRAC_W+WEIGHT_W-1:FRAC_W];
    assign w_shr15  = p_reg[FRAC_W+WEIGHT_W-2:FRAC_W-1];
    assign p_triple = {1'b0, p_reg[34:0]} + {p_reg[34:0], 1'b0};
    assign w_tri16  = p_triple[FRAC_W+WEIGHT_W-1:FRAC_W];

    always_ff @(posedge clk)
    begin
        if (cmd.mul_issue)
        begin
            p_reg <= mul_full[PROD_W-1:0];
        end
        if (cmd.setup)
        begin
            // linear weights; quadratic and cubic overwrite them below
            w_reg[0] <= pos_a;
            w_reg[1] <= '0;
            w_reg[2] <= '0;
            w_reg[3] <= pos_b;
            sum_reg  <= '0;
        end
        else if (cmd.mul_retire)
        begin
            case (cmd.step) inside
                STEP_AA:
                begin
                    aa_reg <= w_shr16;
                    if (is_quad)
                    begin
                        w_reg[0] <= w_shr16;
                    end
                end
                STEP_BB:
                begin
                    bb_reg <= w_shr16;
                    if (is_quad)
                    begin
                        w_reg[3] <= w_shr16;
                    end
                end
                STEP_AB:
                begin
                    if (is_quad)
                    begin
                        w_reg[1] <= w_shr15;
                    end
                end
                STEP_AAA:
                begin
                    if (is_cubic)
                    begin
                        w_reg[0] <= w_shr16;
                    end
                end
                STEP_AAB:
                begin
                    if (is_cubic)
                    begin
                        w_reg[1] <= w_tri16;
                    end
                end
                STEP_ABB:
                begin
                    if (is_cubic)
                    begin
                        w_reg[2] <= w_tri16;
                    end
                end
                STEP_BBB:
                begin
                    if (is_cubic)
                    begin
                        w_reg[3] <= w_shr16;
                    end
                end
                STEP_C0, STEP_C1, STEP_C2, STEP_C3:
                begin
                    sum_reg <= sum_reg + p_reg;
                end
                default: ;
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_value_reg    <= held_reg;
            out_finished_reg <= done_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_value    = out_value_reg;
    assign out_finished = out_finished_reg;

endmodule

>>> rtl/tbr_ctrl.sv
// ----------------------------------------------------------------------------
// Timed Bezier ramp controller
// Sequences one item: accumulate, divide, weight and blend multiplies, emit.
// ----------------------------------------------------------------------------
module tbr_ctrl
    import tbr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [7:0] {
        ST_IDLE     = 8'b0000_0001,
        ST_DIV_INIT = 8'b0000_0010,
        ST_DIV      = 8'b0000_0100,
        ST_SETUP    = 8'b0000_1000,
        ST_ISSUE    = 8'b0001_0000,
        ST_RETIRE   = 8'b0010_0000,
        ST_FINISH   = 8'b0100_0000,
        ST_OUT      = 8'b1000_0000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_CNT_W-1:0]   cnt_next;
    step_t                  step_reg;
    step_t                  step_next;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        step_next      = step_reg;
        in_ready       = 1'b0;
        cmd            = '0;
        cmd.step       = step_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.compute ? ST_DIV_INIT : ST_OUT;
                end
            end
            ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = '0;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + DIV_CNT_W'(1);
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.setup  = 1'b1;
                step_next  = STEP_AA;
                state_next = ST_ISSUE;
            end
            ST_ISSUE:
            begin
                cmd.mul_issue = 1'b1;
                state_next    = ST_RETIRE;
            end
            ST_RETIRE:
            begin
                cmd.mul_retire = 1'b1;
                if (step_reg == STEP_C3)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    step_next  = step_t'(STEP_W'(step_reg) + STEP_W'(1));
                    state_next = ST_ISSUE;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            step_reg  <= STEP_AA;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            step_reg  <= step_next;
        end
    end

endmodule

>>> rtl/timed_bezier_ramp.sv
// ----------------------------------------------------------------------------
// Timed Bezier ramp
// An accepted advance on a running ramp passes through init, 16 divide steps,
// setup, 11 products on one shared multiplier (issue then retire), finish
// and emit; a restart or an advance after finish goes straight to emit.
// One item at a time: a new item is taken only after the last is emitted;
// a result waiting in the output register holds off the input.
// Reset (rst_n low, asynchronous): registers to defaults, ramp and value zero.
// ----------------------------------------------------------------------------
module timed_bezier_ramp
    import tbr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,   // [19:0] elapsed_time
    input  logic                  s_axis_tuser,   // [0] op
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [VALUE_W-1:0]    m_axis_tdata,   // [31:0] value
    output logic                  m_axis_tlast,   // finished
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [VALUE_W-1:0]    cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    tbr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tbr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_op        (s_axis_tuser),
        .in_elapsed   (s_axis_tdata[ELAPSED_W-1:0]),
        .cfg_write    (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_ready    (m_axis_tready),
        .out_valid    (m_axis_tvalid),
        .out_value    (m_axis_tdata),
        .out_finished (m_axis_tlast)
    );

`ifndef SYNTHESIS
    // one item at a time: busy right after an input transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input accepted while an item is in progress");

    // never overwrite a result still waiting in the output register
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("result emitted over a pending output");

    // at most one datapath command per cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load, cmd.div_init, cmd.div_step, cmd.setup,
                  cmd.mul_issue, cmd.mul_retire, cmd.finish, cmd.emit}))
        else $error("conflicting datapath commands");
`endif

endmodule
